>>> design/v7d_pkg.sv
// Shared constants, types and the value finishing function of the varint decoder.
package v7d_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned PAYLOAD_W   = 7;
    localparam int unsigned VALUE_W     = 64;
    localparam int unsigned NARROW_W    = 32;
    localparam int unsigned CFG_IDX_W   = 1;
    localparam int unsigned CFG_DATA_W  = 1;
    localparam int unsigned SLOT_W      = 4;
    localparam int unsigned SHIFT_W     = 7;

    localparam logic [BYTE_W-1:0]    PAYLOAD_MASK = 8'h7f;
    localparam logic [BYTE_W-1:0]    MORE_FLAG    = 8'h80;
    localparam logic [SHIFT_W-1:0]   STEP_BITS    = 7'd7;
    localparam logic [SLOT_W-1:0]    SLOT_LAST    = 4'd10;
    localparam logic [BYTE_W-1:0]    COUNT_MAX    = 8'd255;
    localparam logic [BYTE_W-1:0]    LIMIT_NARROW = 8'd5;
    localparam logic [BYTE_W-1:0]    LIMIT_WIDE   = 8'd10;

    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIGNED_MODE = 1'b1;

    // A finished raw value waiting for sign handling and the length check.
    typedef struct packed {
        logic [VALUE_W-1:0] raw;
        logic [BYTE_W-1:0]  count;
    } gathered_t;

    // Applies the selected width and signedness to a gathered raw value.
    function automatic logic [VALUE_W-1:0] finish_value(
        input logic [VALUE_W-1:0] raw,
        input logic               wide,
        input logic               signed_dec
    );
        logic [VALUE_W-1:0]  mag64;
        logic [NARROW_W-1:0] mag32;
        logic [NARROW_W-1:0] neg32;
        logic [VALUE_W-1:0]  res;
        mag64 = raw >> 1;
        mag32 = raw[NARROW_W-1:0] >> 1;
        neg32 = NARROW_W'(0) - mag32;
        if (wide) begin
            if (!signed_dec) begin
                res = raw;
            end else if (raw[0]) begin
                res = VALUE_W'(0) - mag64;
            end else begin
                res = mag64;
            end
        end else begin
            if (!signed_dec) begin
                res = {{(VALUE_W-NARROW_W){1'b0}}, raw[NARROW_W-1:0]};
            end else if (raw[0]) begin
                res = {{(VALUE_W-NARROW_W){neg32[NARROW_W-1]}}, neg32};
            end else begin
                res = {{(VALUE_W-NARROW_W){1'b0}}, mag32};
            end
        end
        return res;
    endfunction

endpackage

>>> design/varint7_stream_decoder.sv
// Top level of the little-endian 7-bit varint stream decoder.
//
// The decoder takes one encoded byte per input transfer and produces one result
// transfer for every byte whose top bit is clear. The low seven bits of each byte
// are ORed into a 64-bit accumulator at a shift that rises by seven per byte;
// payload that would land at bit 64 or above is dropped. A byte can be accepted in
// every clock cycle: the gathering registers absorb each byte, a finished raw
// value then moves into a holding stage, and once the output register is free
// the finishing logic (width masking, sign handling with bit 0 as the sign, and
// the length check) writes the output register from it. Throughput is one byte
// per cycle as long as the result side keeps taking transfers. Configuration
// is written through a plain write port: index 0 selects 64-bit decoding,
// index 1 selects signed decoding. The settings that hold when a value
// finishes decide its masking, sign handling and over-long limit (more than 5
// bytes in 32-bit mode, more than 10 in 64-bit mode). The reported byte count
// saturates at 255.
module varint7_stream_decoder (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [v7d_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [v7d_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [v7d_pkg::BYTE_W-1:0]       s_stream_byte,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [v7d_pkg::VALUE_W-1:0]      m_decoded_value,
    output logic [v7d_pkg::BYTE_W-1:0]       m_bytes_used,
    output logic                             m_over_long
);
    import v7d_pkg::*;

    // Configuration registers.
    logic wide_mode_reg;
    logic signed_mode_reg;

    // Gathering state for the value in progress.
    logic [VALUE_W-1:0] acc_reg,   acc_next;
    logic [SLOT_W-1:0]  slot_reg,  slot_next;
    logic [BYTE_W-1:0]  count_reg, count_next;

    // Holding stage between gathering and finishing.
    logic       mid_valid_reg;
    gathered_t  mid_reg;

    // Output register.
    logic               out_valid_reg;
    logic [VALUE_W-1:0] out_value_reg;
    logic [BYTE_W-1:0]  out_bytes_reg;
    logic               out_over_reg;

    logic               in_xfer;
    logic               last_byte;
    logic               out_free;
    logic               mid_adv;
    logic [SHIFT_W-1:0] shift_amt;
    logic [VALUE_W-1:0] placed;
    logic [BYTE_W-1:0]  limit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wide_mode_reg   <= 1'b0;
            signed_mode_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_WIDE_MODE:   wide_mode_reg   <= cfg_wdata[0];
                CFG_SIGNED_MODE: signed_mode_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // The result side frees a slot when the output register is empty or is being
    // taken; the holding stage moves on whenever that slot is free.
    assign out_free  = !out_valid_reg || m_ready;
    assign mid_adv   = mid_valid_reg && out_free;
    assign s_ready   = !mid_valid_reg || mid_adv;
    assign in_xfer   = s_valid && s_ready;
    assign last_byte = (s_stream_byte & MORE_FLAG) == '0;

    // Slot k places payload at bit 7*k; slot ten and beyond means the shift has
    // passed the top of the accumulator and payload is dropped.
    assign shift_amt = SHIFT_W'(slot_reg) * STEP_BITS;
    assign placed    = VALUE_W'(s_stream_byte & PAYLOAD_MASK) << shift_amt;

    always_comb begin
        acc_next   = acc_reg;
        slot_next  = slot_reg;
        count_next = count_reg;
        if (slot_reg != SLOT_LAST) begin
            acc_next  = acc_reg | placed;
            slot_next = slot_reg + SLOT_W'(1);
        end
        if (count_reg != COUNT_MAX) begin
            count_next = count_reg + BYTE_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg   <= '0;
            slot_reg  <= '0;
            count_reg <= '0;
        end else if (in_xfer) begin
            if (last_byte) begin
                acc_reg   <= '0;
                slot_reg  <= '0;
                count_reg <= '0;
            end else begin
                acc_reg   <= acc_next;
                slot_reg  <= slot_next;
                count_reg <= count_next;
            end
        end
    end

    // A terminating byte hands its completed raw value to the holding stage.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mid_valid_reg <= 1'b0;
        end else if (in_xfer && last_byte) begin
            mid_valid_reg <= 1'b1;
        end else if (mid_adv) begin
            mid_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_xfer && last_byte) begin
            mid_reg.raw   <= acc_next;
            mid_reg.count <= count_next;
        end
    end

    assign limit = wide_mode_reg ? LIMIT_WIDE : LIMIT_NARROW;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (mid_adv) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (mid_adv) begin
            out_value_reg <= finish_value(mid_reg.raw, wide_mode_reg, signed_mode_reg);
            out_bytes_reg <= mid_reg.count;
            out_over_reg  <= mid_reg.count > limit;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_decoded_value = out_value_reg;
    assign m_bytes_used    = out_bytes_reg;
    assign m_over_long     = out_over_reg;

endmodule

>>> tb/sv/tb_varint7_stream_decoder.sv
// Self-checking testbench for the varint stream decoder, with its own decode predictor.
module tb_varint7_stream_decoder;
    import v7d_pkg::*;

    // One decoded value as it should leave the result channel.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [BYTE_W-1:0]  used;
        logic               over;
    } decoded_t;

    logic                  aclk            = 1'b0;
    logic                  aresetn         = 1'b0;
    logic                  cfg_wr_en       = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index       = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata       = '0;
    logic                  s_valid         = 1'b0;
    logic                  s_ready;
    logic [BYTE_W-1:0]     s_stream_byte   = '0;
    logic                  m_valid;
    logic                  m_ready         = 1'b0;
    logic [VALUE_W-1:0]    m_decoded_value;
    logic [BYTE_W-1:0]     m_bytes_used;
    logic                  m_over_long;

    // Mirror of the decoder's configuration and gathering state.
    logic                  wide_sel      = 1'b0;
    logic                  signed_sel    = 1'b0;
    logic [VALUE_W-1:0]    gathered_bits = '0;
    int unsigned           bit_offset    = 0;
    logic [BYTE_W-1:0]     byte_tally    = '0;

    // Decoded values predicted but not yet seen on the result channel, oldest first.
    decoded_t              pending_values[$];

    int unsigned           error_count  = 0;
    int unsigned           values_seen  = 0;
    int unsigned           bytes_sent   = 0;

    // While set, neither side of the block inserts idle cycles.
    bit                    no_gaps = 1'b0;

    always #1 aclk = ~aclk;

    varint7_stream_decoder uut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_stream_byte   (s_stream_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_decoded_value (m_decoded_value),
        .m_bytes_used    (m_bytes_used),
        .m_over_long     (m_over_long)
    );

    // Applies the current width and sign settings to a gathered 64-bit pattern.
    // In signed mode bit 0 carries the sign and the bits above it the magnitude,
    // so a set sign with a zero magnitude simply comes out as zero.
    function automatic logic [VALUE_W-1:0] format_value(input logic [VALUE_W-1:0] raw);
        logic [VALUE_W-1:0]  magnitude;
        logic [NARROW_W-1:0] low_word;
        if (wide_sel) begin
            magnitude = raw >> 1;
            if (!signed_sel) return raw;
            return raw[0] ? 64'd0 - magnitude : magnitude;
        end
        low_word = raw[NARROW_W-1:0];
        if (!signed_sel) return {32'd0, low_word};
        low_word = low_word >> 1;
        if (raw[0]) low_word = 32'd0 - low_word;
        // A positive magnitude never reaches bit 31, so this extension is exact.
        return {{32{low_word[NARROW_W-1]}}, low_word};
    endfunction

    // Folds one accepted byte into the predicted state and, when the byte ends
    // a value, queues the result that the block has to produce for it.
    function automatic void absorb_byte(input logic [BYTE_W-1:0] b);
        decoded_t result;
        // Payload at a shift of 64 or more is dropped and the shift stops rising.
        if (bit_offset < VALUE_W) begin
            gathered_bits |= {56'd0, b & PAYLOAD_MASK} << bit_offset;
            bit_offset += STEP_BITS;
        end
        if (byte_tally != COUNT_MAX) byte_tally++;
        if ((b & MORE_FLAG) == 0) begin
            result.value = format_value(gathered_bits);
            result.used  = byte_tally;
            result.over  = byte_tally > (wide_sel ? LIMIT_WIDE : LIMIT_NARROW);
            pending_values.push_back(result);
            gathered_bits = '0;
            bit_offset    = 0;
            byte_tally    = '0;
        end
    endfunction

    // The result side stalls at random unless a gap-free stretch is running.
    always @(posedge aclk) begin
        m_ready <= no_gaps || ($urandom_range(99) >= 26);
    end

    // Every result transfer is matched against the oldest predicted value.
    always @(posedge aclk) begin : check_results
        decoded_t want;
        if (aresetn && m_valid && m_ready) begin
            values_seen++;
            if (pending_values.size() == 0) begin
                $error("unexpected result transfer: value %h, bytes %0d, over_long %0b",
                       m_decoded_value, m_bytes_used, m_over_long);
                error_count++;
            end else begin
                want = pending_values.pop_front();
                if (m_decoded_value !== want.value) begin
                    $error("decoded_value: expected %h, got %h", want.value, m_decoded_value);
                    error_count++;
                end
                if (m_bytes_used !== want.used) begin
                    $error("bytes_used: expected %0d, got %0d", want.used, m_bytes_used);
                    error_count++;
                end
                if (m_over_long !== want.over) begin
                    $error("over_long: expected %0b, got %0b", want.over, m_over_long);
                    error_count++;
                end
            end
        end
    end

    // Sends one stream byte. Valid stays high from one byte to the next unless a
    // random gap is taken, so back-to-back transfers happen whenever ready allows.
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (!no_gaps) begin
            while ($urandom_range(99) < 26) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid       <= 1'b1;
        s_stream_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        absorb_byte(b);
        bytes_sent++;
    endtask

    // Holds the sender off until every predicted value has arrived and the
    // two-stage pipeline is empty, then idles before returning.
    task automatic wait_for_drain();
        s_valid <= 1'b0;
        while (pending_values.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Writes both registers while the block is quiet and mirrors them.
    task automatic set_modes(input logic wide, input logic sgn);
        wait_for_drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_WIDE_MODE;
        cfg_wdata <= wide;
        @(posedge aclk);
        cfg_index <= CFG_SIGNED_MODE;
        cfg_wdata <= sgn;
        @(posedge aclk);
        cfg_wr_en  <= 1'b0;
        wide_sel   = wide;
        signed_sel = sgn;
    endtask

    // Emits the shortest encoding of a value, low groups first.
    task automatic send_encoded(input logic [VALUE_W-1:0] v);
        logic [VALUE_W-1:0] rest;
        logic [BYTE_W-1:0]  b;
        rest = v;
        do begin
            b    = {1'b0, rest[6:0]};
            rest = rest >> 7;
            if (rest != 0) b |= MORE_FLAG;
            send_byte(b);
        end while (rest != 0);
    endtask

    // One random value: mostly proper encodings of random-width numbers or
    // random payload groups, with some stray single bytes and over-long runs.
    task automatic send_random_varint();
        int unsigned       kind;
        int unsigned       len;
        logic [VALUE_W-1:0] v;
        logic [BYTE_W-1:0] p;
        kind = $urandom_range(9);
        if (kind == 0) begin
            send_byte(BYTE_W'($urandom_range(255)));
        end else if (kind <= 4) begin
            len = $urandom_range(1, 64);
            v   = {$urandom, $urandom};
            if (len < 64) v &= (64'd1 << len) - 64'd1;
            send_encoded(v);
        end else begin
            len = (kind == 5) ? $urandom_range(11, 20) : $urandom_range(1, 10);
            for (int i = 0; i < len; i++) begin
                case ($urandom_range(3))
                    0:       p = PAYLOAD_MASK;
                    1:       p = '0;
                    default: p = BYTE_W'($urandom_range(127));
                endcase
                if (i != len - 1) p |= MORE_FLAG;
                send_byte(p);
            end
        end
    endtask

    // Field extremes in both widths, excess payload, an over-long narrow
    // value, and negative zero.
    task automatic test_directed_values();
        set_modes(1'b0, 1'b0);
        send_byte(8'h00);
        send_byte(PAYLOAD_MASK);
        // Largest 32-bit value; the upper payload bits of the last byte are dropped.
        repeat (4) send_byte(8'hff);
        send_byte(PAYLOAD_MASK);
        // A zero value spread over six bytes is one byte too long for 32 bits.
        repeat (5) send_byte(MORE_FLAG);
        send_byte(8'h00);
        set_modes(1'b0, 1'b1);
        send_byte(8'h01);
        // All 64 bits set in signed mode gives the most negative magnitude.
        set_modes(1'b1, 1'b1);
        repeat (9) send_byte(8'hff);
        send_byte(PAYLOAD_MASK);
    endtask

    // Settings written between the bytes of one value: the settings in force
    // when the last byte arrives decide the result.
    task automatic test_mode_change_mid_value();
        set_modes(1'b0, 1'b0);
        repeat (5) send_byte(8'hff);
        set_modes(1'b1, 1'b1);
        send_byte(8'h01);
        set_modes(1'b1, 1'b0);
        repeat (6) send_byte(8'hff);
        set_modes(1'b0, 1'b1);
        send_byte(8'h02);
    endtask

    // Streams long enough that the shift hits its ceiling and the count saturates.
    task automatic test_long_stream();
        set_modes(1'b1, 1'b0);
        repeat (299) send_byte(MORE_FLAG | BYTE_W'($urandom_range(127)));
        send_byte(8'h00);
        set_modes(1'b0, 1'b1);
        repeat (259) send_byte(MORE_FLAG | BYTE_W'($urandom_range(127)));
        send_byte(BYTE_W'($urandom_range(127)));
    endtask

    // A stretch at full rate on both sides.
    task automatic test_back_to_back();
        int unsigned start;
        set_modes(1'(($urandom_range(1))), 1'($urandom_range(1)));
        no_gaps = 1'b1;
        start   = bytes_sent;
        while (bytes_sent - start < 300) send_random_varint();
        no_gaps = 1'b0;
    endtask

    // Random traffic under each combination of settings, every one visited twice.
    task automatic test_random_phases();
        int unsigned start;
        for (int phase = 0; phase < 8; phase++) begin
            set_modes(1'(phase % 2), 1'((phase / 2) % 2));
            start = bytes_sent;
            while (bytes_sent - start < 125) send_random_varint();
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_values();
        test_mode_change_mid_value();
        test_long_stream();
        test_back_to_back();
        test_random_phases();

        wait_for_drain();
        repeat (8) @(posedge aclk);

        $display("Sent %0d stream bytes and checked %0d decoded values in all four modes.",
                 bytes_sent, values_seen);
        $display("Included extremes, over-long and saturating runs, and mid-value mode writes.");
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Guard against a hung handshake; far beyond the slowest correct run.
    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule
